// ----- rtl/cpvp_pkg.sv -----
// Shared types and constants for the cascaded position / velocity PI core.
package cpvp_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int TIME_WIDTH_DEF    = 32;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_TURN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATION_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_TARGET  = 3'd5;

	localparam int SAMPLE_GAP     = 100;
	localparam int CONTROL_PERIOD = 2000;
	localparam int PWM_LIMIT      = 255;
	localparam int JUMP_LIMIT     = 50;
	localparam int SMALL_DIVISOR  = 1000;
	localparam int ANGLE_SPAN     = 720;
	localparam int TGT_BITS       = 27;
	localparam int SAT_W          = 80;

	// divide by 720 as a shift by 4, then a multiply by ceil(2^29 / 45) and a shift by 29
	localparam int          TGT_SHIFT     = 4;
	localparam int          TGT_RCP_SHIFT = 29;
	localparam logic [23:0] TGT_RECIP     = 24'd11930465;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_DIV,
		ST_DIV_DONE,
		ST_CTRL,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_FIN,
		ST_PERR,
		ST_DRIVE,
		ST_JUMP,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DOP_VEL,
		DOP_AVG
	} dop_t;

	typedef enum logic [2:0] {
		MOP_TGT,
		MOP_RCP,
		MOP_PERR,
		MOP_VEL,
		MOP_INT,
		MOP_STEP
	} mop_t;

endpackage

// ----- rtl/cascaded_position_velocity_pi_core.sv -----
// Cascaded position / velocity PI core: sequencer, shared divider and shared multiplier.
// With neither a sample nor a loop due, an input goes from ST_SAMPLE through ST_CTRL and ST_JUMP to ST_OUT.
// A velocity sample adds a pass of the restoring divider (one bit a cycle).
// A loop update adds the shared multiplier passes, plus the 48-bit average divide when samples exist.
// One item at a time: a new input is taken only in ST_IDLE, after the last result is taken.
// Reset (arst_n low, asynchronous): sequencer and architectural state zero, configuration registers at defaults.
module cascaded_position_velocity_pi_core #(
	parameter int FRACTION_BITS = cpvp_pkg::FRACTION_BITS_DEF,
	parameter int TIME_WIDTH    = cpvp_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cpvp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    time_us,
	input  logic signed [31:0]             encoder_position,
	input  logic [9:0]                     target_angle,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     pwm_duty,
	output logic                           direction,
	output logic                           loop_ran
);
	import cpvp_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int TW    = TIME_WIDTH;
	localparam int VBITS = 33 + F;
	localparam int DW    = (VBITS > 48) ? VBITS : 48;
	localparam int DVW   = TW;
	localparam int CW    = $clog2(DW + 1);
	localparam int SW    = SAT_W;
	localparam logic signed [SW-1:0] V48_MAX = SW'(48'h7FFF_FFFF_FFFF);
	localparam logic signed [SW-1:0] V48_MIN = -V48_MAX - SW'(1);
	localparam logic [71:0] R_CAP = 72'(1) << 47;
	localparam logic signed [47:0] LIM = 48'(PWM_LIMIT) << F;
	localparam logic [47:0] SMALL_THR = 48'((64'(1) << F) / SMALL_DIVISOR);
	localparam logic signed [SW-1:0] JUMP_THR = SW'(JUMP_LIMIT) << F;

	function automatic logic [47:0] mag48(input logic [47:0] x);
		return x[47] ? (~x + 48'd1) : x;
	endfunction

	function automatic logic [23:0] mag24(input logic [23:0] x);
		return x[23] ? (~x + 24'd1) : x;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [SW-1:0] x);
		logic signed [47:0] r;
		if (x > V48_MAX) begin
			r = V48_MAX[47:0];
		end else if (x < V48_MIN) begin
			r = V48_MIN[47:0];
		end else begin
			r = x[47:0];
		end
		return r;
	endfunction

	// configuration registers
	logic [15:0]        cpt_q;
	logic signed [23:0] pos_gain_q, vel_gain_q, int_gain_q;
	logic [23:0]        int_step_q;
	logic signed [31:0] vel_target_q;

	// architectural state
	state_t             state_q, state_d;
	logic [TW-1:0]      sample_time_q, control_time_q;
	logic signed [31:0] prev_pos_q;
	logic signed [47:0] vel_sum_q, err_int_q, drive_now_q, drive_before_q;
	logic [15:0]        sample_cnt_q;
	logic [7:0]         pwm_q;
	logic               dir_q, ran_q;

	// working registers
	logic [TW-1:0]      t_q;
	logic signed [31:0] enc_q;
	logic [9:0]         angle_q;
	logic               dx_neg_q;
	logic [DW-1:0]      div_q_q;
	logic [DVW-1:0]     div_r_q, div_d_q;
	logic [CW-1:0]      div_cnt_q;
	dop_t               dop_q;
	logic [47:0]        mul_a_q;
	logic [23:0]        mul_b_q;
	logic               mul_neg_q;
	mop_t               mop_q;
	logic [47:0]        mul_p_q, mul_lo_q;
	logic [18:0]        target_q;
	logic signed [47:0] avg_q, verr_q, t1_q, u_q, t3_q;
	logic               vel_sum_sign_q;

	// sequencer controls
	logic           div_start;
	logic [DW-1:0]  div_dividend;
	logic [DVW-1:0] div_divisor;
	logic [CW-1:0]  div_bits;
	dop_t           div_op;
	logic           mul_start;
	logic [47:0]    mul_a;
	logic [23:0]    mul_b;
	logic           mul_neg;
	mop_t           mul_op;

	// datapath
	logic [TW-1:0]        dt_w;
	logic                 sample_due, loop_due;
	logic signed [32:0]   dx_w;
	logic [32:0]          dx_mag;
	logic [DVW+1:0]       trial_w;
	logic [47:0]          mul_prod_w;
	logic [71:0]          mul_full_w;
	logic [71:0]          mq_r, mq_c;
	logic signed [SW-1:0] mq_s;
	logic signed [47:0]   mq_w;
	logic signed [SW-1:0] p_s;
	logic signed [47:0]   verr_w;
	logic signed [33:0]   perr_w;
	logic [33:0]          perr_mag;
	logic signed [SW-1:0] vel_s;
	logic [47:0]          u_mag;
	logic signed [SW-1:0] jump_w;

	assign dt_w       = t_q - sample_time_q;
	assign sample_due = dt_w > TW'(SAMPLE_GAP);
	assign loop_due   = (t_q - control_time_q) >= TW'(CONTROL_PERIOD);
	assign dx_w       = {enc_q[31], enc_q} - {prev_pos_q[31], prev_pos_q};
	assign dx_mag     = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
	assign trial_w    = {1'b0, div_r_q, div_q_q[DW-1]} - {2'b00, div_d_q};
	assign mul_prod_w = 48'(mul_b_q) * 48'((state_q == ST_MUL_LO) ? mul_a_q[23:0]
		: mul_a_q[47:24]);
	assign mul_full_w = {mul_p_q, 24'd0} + 72'(mul_lo_q);
	assign mq_r       = mul_full_w >> F;
	assign mq_c       = (mq_r > R_CAP) ? R_CAP : mq_r;
	assign mq_s       = SW'(mq_c[47:0]);
	assign mq_w       = sat48(mul_neg_q ? -mq_s : mq_s);
	assign p_s        = SW'(mul_full_w);
	assign verr_w     = sat48((mul_neg_q ? -p_s : p_s) + SW'(vel_target_q) - SW'(avg_q));
	assign perr_w     = $signed({15'd0, target_q}) - {{2{enc_q[31]}}, enc_q};
	assign perr_mag   = perr_w[33] ? (~perr_w + 34'd1) : perr_w;
	assign vel_s      = dx_neg_q ? -SW'(div_q_q) : SW'(div_q_q);
	assign u_mag      = mag48(u_q);
	assign jump_w     = SW'(drive_now_q) - SW'(drive_before_q);

	assign cfg_ready = 1'b1;
	assign pwm_duty  = pwm_q;
	assign direction = dir_q;
	assign loop_ran  = ran_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SAMPLE;
			ST_SAMPLE:   state_d = sample_due ? ST_DIV : ST_CTRL;
			ST_DIV:      if (div_cnt_q == CW'(1)) state_d = ST_DIV_DONE;
			ST_DIV_DONE: begin
				unique case (dop_q)
					DOP_VEL: state_d = ST_CTRL;
					DOP_AVG: state_d = ST_PERR;
					default: state_d = ST_PERR;
				endcase
			end
			ST_CTRL:     state_d = loop_due ? ST_MUL_LO : ST_JUMP;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_MUL_FIN;
			ST_MUL_FIN: begin
				unique case (mop_q)
					MOP_RCP:  state_d = (sample_cnt_q != 16'd0) ? ST_DIV : ST_PERR;
					MOP_STEP: state_d = ST_DRIVE;
					default:  state_d = ST_MUL_LO;
				endcase
			end
			ST_PERR:     state_d = ST_MUL_LO;
			ST_DRIVE:    state_d = ST_JUMP;
			ST_JUMP:     state_d = ST_OUT;
			ST_OUT:      if (out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_valid    = (state_q == ST_OUT);
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		div_bits     = '0;
		div_op       = DOP_VEL;
		mul_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		mul_neg      = 1'b0;
		mul_op       = MOP_TGT;
		unique case (state_q)
			ST_SAMPLE: begin
				if (sample_due) begin
					div_start    = 1'b1;
					div_dividend = DW'({dx_mag, {F{1'b0}}}) << (DW - VBITS);
					div_divisor  = dt_w;
					div_bits     = CW'(VBITS);
					div_op       = DOP_VEL;
				end
			end
			ST_CTRL: begin
				if (loop_due) begin
					mul_start = 1'b1;
					mul_a     = 48'({angle_q, 1'b0});
					mul_b     = 24'(cpt_q);
					mul_op    = MOP_TGT;
				end
			end
			ST_PERR: begin
				mul_start = 1'b1;
				mul_a     = 48'(perr_mag);
				mul_b     = mag24(pos_gain_q);
				mul_neg   = perr_w[33] ^ pos_gain_q[23];
				mul_op    = MOP_PERR;
			end
			ST_MUL_FIN: begin
				unique case (mop_q)
					MOP_TGT: begin
						mul_start = 1'b1;
						mul_a     = 48'(mul_full_w[TGT_BITS-1:TGT_SHIFT]);
						mul_b     = TGT_RECIP;
						mul_op    = MOP_RCP;
					end
					MOP_RCP: begin
						if (sample_cnt_q != 16'd0) begin
							div_start    = 1'b1;
							div_dividend = DW'(mag48(vel_sum_q)) << (DW - 48);
							div_divisor  = DVW'(sample_cnt_q);
							div_bits     = CW'(48);
							div_op       = DOP_AVG;
						end
					end
					MOP_PERR: begin
						mul_start = 1'b1;
						mul_a     = mag48(verr_w);
						mul_b     = mag24(vel_gain_q);
						mul_neg   = verr_w[47] ^ vel_gain_q[23];
						mul_op    = MOP_VEL;
					end
					MOP_VEL: begin
						mul_start = 1'b1;
						mul_a     = mag48(err_int_q);
						mul_b     = mag24(int_gain_q);
						mul_neg   = err_int_q[47] ^ int_gain_q[23];
						mul_op    = MOP_INT;
					end
					MOP_INT: begin
						mul_start = 1'b1;
						mul_a     = mag48(verr_q);
						mul_b     = int_step_q;
						mul_neg   = verr_q[47];
						mul_op    = MOP_STEP;
					end
					default: begin
						mul_start = 1'b0;
					end
				endcase
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			div_cnt_q      <= '0;
			cpt_q          <= 16'd1024;
			pos_gain_q     <= 24'sd65536;
			vel_gain_q     <= 24'sd65536;
			int_gain_q     <= '0;
			int_step_q     <= 24'd65536;
			vel_target_q   <= '0;
			sample_time_q  <= '0;
			control_time_q <= '0;
			prev_pos_q     <= '0;
			vel_sum_q      <= '0;
			sample_cnt_q   <= '0;
			err_int_q      <= '0;
			drive_now_q    <= '0;
			drive_before_q <= '0;
			pwm_q          <= '0;
			dir_q          <= 1'b0;
			ran_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_COUNTS_PER_TURN:  cpt_q        <= cfg_data[15:0];
					CFG_POSITION_GAIN:    pos_gain_q   <= cfg_data[23:0];
					CFG_VELOCITY_GAIN:    vel_gain_q   <= cfg_data[23:0];
					CFG_INTEGRAL_GAIN:    int_gain_q   <= cfg_data[23:0];
					CFG_INTEGRATION_STEP: int_step_q   <= cfg_data[23:0];
					CFG_VELOCITY_TARGET:  vel_target_q <= cfg_data;
					default: ;
				endcase
			end
			if (div_start) begin
				div_cnt_q <= div_bits;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - CW'(1);
			end
			unique case (state_q)
				ST_SAMPLE: begin
					if (sample_due) begin
						sample_time_q <= t_q;
						prev_pos_q    <= enc_q;
						if (sample_cnt_q != 16'hFFFF) sample_cnt_q <= sample_cnt_q + 16'd1;
					end
				end
				ST_DIV_DONE: begin
					if (dop_q == DOP_VEL) begin
						vel_sum_q <= sat48(SW'(vel_sum_q) + vel_s);
					end
				end
				ST_MUL_FIN: begin
					if (mop_q == MOP_RCP) begin
						vel_sum_q    <= '0;
						sample_cnt_q <= '0;
					end
				end
				ST_CTRL: begin
					ran_q <= loop_due;
					if (loop_due) control_time_q <= t_q;
				end
				ST_DRIVE: begin
					if (u_q > 48'sd0) dir_q <= 1'b0;
					else if (u_q < 48'sd0) dir_q <= 1'b1;
					if (u_q > LIM) begin
						drive_now_q <= LIM;
						pwm_q       <= 8'(PWM_LIMIT);
					end else if (u_q < -LIM) begin
						drive_now_q <= -LIM;
						pwm_q       <= 8'(PWM_LIMIT);
					end else begin
						drive_now_q <= u_q;
						if (u_mag > SMALL_THR) begin
							pwm_q     <= 8'(u_mag >> F);
							err_int_q <= sat48(SW'(err_int_q) + SW'(t3_q));
						end
					end
				end
				ST_JUMP: begin
					if (jump_w > JUMP_THR || jump_w < -JUMP_THR) pwm_q <= '0;
					drive_before_q <= drive_now_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t_q     <= TW'(time_us);
			enc_q   <= encoder_position;
			angle_q <= target_angle;
		end
		if (state_q == ST_SAMPLE) dx_neg_q <= dx_w[32];
		if (div_start) begin
			div_q_q <= div_dividend;
			div_r_q <= '0;
			div_d_q <= div_divisor;
			dop_q   <= div_op;
		end else if (state_q == ST_DIV) begin
			if (!trial_w[DVW+1]) begin
				div_r_q <= trial_w[DVW-1:0];
				div_q_q <= {div_q_q[DW-2:0], 1'b1};
			end else begin
				div_r_q <= {div_r_q[DVW-2:0], div_q_q[DW-1]};
				div_q_q <= {div_q_q[DW-2:0], 1'b0};
			end
		end
		if (mul_start) begin
			mul_a_q   <= mul_a;
			mul_b_q   <= mul_b;
			mul_neg_q <= mul_neg;
			mop_q     <= mul_op;
		end
		if (state_q == ST_MUL_LO) mul_p_q <= mul_prod_w;
		if (state_q == ST_MUL_HI) begin
			mul_lo_q <= mul_p_q;
			mul_p_q  <= mul_prod_w;
		end
		if (state_q == ST_DIV_DONE) begin
			if (dop_q == DOP_AVG) begin
				avg_q <= vel_sum_sign_q ? -$signed(div_q_q[47:0]) : $signed(div_q_q[47:0]);
			end
		end
		if (state_q == ST_MUL_FIN) begin
			unique case (mop_q)
				MOP_RCP: begin
					target_q <= mul_full_w[TGT_RCP_SHIFT+18:TGT_RCP_SHIFT];
					avg_q    <= '0;
				end
				MOP_PERR: verr_q <= verr_w;
				MOP_VEL:  t1_q   <= mq_w;
				MOP_INT:  u_q    <= sat48(SW'(t1_q) + SW'(mq_w));
				MOP_STEP: t3_q   <= mq_w;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start && div_op == DOP_AVG) vel_sum_sign_q <= vel_sum_q[47];
	end

`ifndef ASSERT_OFF
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("sequencer did not leave idle after input transfer");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("sequencer did not return to idle after output transfer");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_cnt_q != '0)
		else $error("divider running with zero step count");
`endif

endmodule
